// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the heap queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/dhpq_pkg.sv -----
// Package: constants, codes and command/status types for the heap queue
`default_nettype none
package dhpq_pkg;
    localparam int CAPACITY   = 256;
    localparam int MAX_DEGREE = 8;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = AW + 1;
    localparam int DW         = 4;

    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT  = 2'd1;
    localparam logic [1:0] FUNC_INCREASE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    // Datapath command codes
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;  // latch input item
    localparam logic [3:0] CMD_INS_WR    = 4'd2;  // write key at count, pos=count
    localparam logic [3:0] CMD_EXT_RD0   = 4'd3;  // read root
    localparam logic [3:0] CMD_EXT_RDL   = 4'd4;  // capture root, read last
    localparam logic [3:0] CMD_EXT_WR0   = 4'd5;  // cur=last, write root
    localparam logic [3:0] CMD_INC_RD    = 4'd6;  // read entry at index
    localparam logic [3:0] CMD_INC_WR    = 4'd7;  // saturating add, write back
    localparam logic [3:0] CMD_UP_RD     = 4'd8;  // read parent
    localparam logic [3:0] CMD_UP_CMP    = 4'd9;  // compare, write parent
    localparam logic [3:0] CMD_UP_WR     = 4'd10; // write moved parent down
    localparam logic [3:0] CMD_DN_START  = 4'd11; // set first child, read it
    localparam logic [3:0] CMD_DN_SCAN   = 4'd12; // compare a child, read next
    localparam logic [3:0] CMD_DN_SWAP   = 4'd13; // write child into pos
    localparam logic [3:0] CMD_DN_WR     = 4'd14; // write cur into best

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       full;
        logic       bad_idx;
        logic       at_root;
        logic       up_move;
        logic       dn_leaf;
        logic       scan_last;
        logic       dn_move;
    } t_stat;
endpackage
`default_nettype wire

// ----- hdl/dary_max_heap_priority_queue_unit.sv -----
// Top level: d-ary max-heap priority queue
// One item at a time, results held in an output register. Insert and
// increase-key move the key up level by level; extract-max moves the last key
// down from the root, and the single memory port reads one child per cycle
// while it scans the children of a node. Errors and the unused code skip
// the heap and go straight to the result.
`default_nettype none
module dary_max_heap_priority_queue_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_func,
    input  wire logic signed [31:0]          i_key,
    input  wire logic [7:0]                  i_index,
    input  wire logic [30:0]                 i_amount,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [31:0]               o_max_key,
    output logic [1:0]                       o_status,
    output logic [dhpq_pkg::CW-1:0]          o_count,
    input  wire logic                        i_degree_we,
    input  wire logic [dhpq_pkg::DW-1:0]     i_degree
);
    import dhpq_pkg::*;

    logic [DW-1:0] r_degree;
    t_cmd  cmd;
    t_stat stat;
    logic  finish;

    // Degree register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_degree <= DW'(2);
        else if (i_degree_we) r_degree <= i_degree;
    end

    dhpq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd(cmd), .i_stat(stat),
        .o_finish(finish)
    );

    dhpq_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_func(i_func), .i_key(i_key), .i_index(i_index), .i_amount(i_amount),
        .i_degree(r_degree), .i_finish(finish), .o_max_key(o_max_key),
        .o_status(o_status), .o_count(o_count)
    );
endmodule
`default_nettype wire

// ----- hdl/dhpq_ram.sv -----
// Generic single-port RAM with registered read
`default_nettype none
module dhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- hdl/dhpq_datapath.sv -----
// Datapath: heap memory, position registers, comparators and result
`default_nettype none
module dhpq_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dhpq_pkg::t_cmd         i_cmd,
    output dhpq_pkg::t_stat             o_stat,
    input  wire logic [1:0]             i_func,
    input  wire logic signed [31:0]     i_key,
    input  wire logic [7:0]             i_index,
    input  wire logic [30:0]            i_amount,
    input  wire logic [dhpq_pkg::DW-1:0] i_degree,
    input  wire logic                   i_finish,
    output logic signed [31:0]          o_max_key,
    output logic [1:0]                  o_status,
    output logic [dhpq_pkg::CW-1:0]     o_count
);
    import dhpq_pkg::*;

    logic [1:0]         r_func;
    logic signed [31:0] r_key;
    logic [7:0]         r_index;
    logic [30:0]        r_amount;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_pos, r_par, r_best, r_child;
    logic [DW-1:0]      r_left;
    logic signed [31:0] r_cur, r_bestk, r_res;
    logic [1:0]         r_st;
    logic [DW-1:0]      w_d;
    logic               we;
    logic [AW-1:0]      addr;
    logic [31:0]        wdata, rdata;
    logic signed [31:0] rk;
    logic [AW+DW+1:0]   w_first;
    logic [AW-1:0]      w_pm1;
    logic [AW:0]        w_recip;
    logic [3:0]         w_sh;
    logic [2*AW:0]      w_prod;
    logic [AW-1:0]      w_par;
    logic signed [32:0] w_sum;

    assign rk = rdata;

    // Clamp degree to [2, MAX_DEGREE]
    always_comb begin
        if (i_degree < DW'(2)) w_d = DW'(2);
        else if (i_degree > DW'(MAX_DEGREE)) w_d = DW'(MAX_DEGREE);
        else w_d = i_degree;
    end

    // Parent (pos - 1) / d by reciprocal multiply, exact for positions below 256
    always_comb begin
        w_pm1 = r_pos - 1'b1;
        case (w_d)
            DW'(3): begin w_recip = 9'd171; w_sh = 4'd9;  end
            DW'(4): begin w_recip = 9'd256; w_sh = 4'd10; end
            DW'(5): begin w_recip = 9'd205; w_sh = 4'd10; end
            DW'(6): begin w_recip = 9'd171; w_sh = 4'd10; end
            DW'(7): begin w_recip = 9'd293; w_sh = 4'd11; end
            DW'(8): begin w_recip = 9'd256; w_sh = 4'd11; end
            default: begin w_recip = 9'd256; w_sh = 4'd9; end
        endcase
        w_prod = {{(AW+1){1'b0}}, w_pm1} * {{AW{1'b0}}, w_recip};
        w_par = AW'(w_prod >> w_sh);
    end

    assign w_first = {{(DW+2){1'b0}}, r_pos} * {{(AW+2){1'b0}}, w_d} + 1'b1;
    assign w_sum = {rk[31], rk} + {2'b00, r_amount};

    // Memory port steering
    always_comb begin
        we = 1'b0;
        addr = r_pos;
        wdata = r_cur;
        case (i_cmd.op)
            CMD_INS_WR: begin
                we = 1'b1; addr = r_count[AW-1:0]; wdata = r_key;
            end
            CMD_EXT_RD0: addr = '0;
            CMD_EXT_RDL: addr = r_count[AW-1:0];  // count already decremented
            CMD_EXT_WR0: begin
                we = 1'b1; addr = '0; wdata = rk;
            end
            CMD_INC_RD:  addr = r_index[AW-1:0];
            CMD_INC_WR: begin
                we = 1'b1; addr = r_pos;
                wdata = (w_sum > 33'sh7FFFFFFF) ? 32'h7FFFFFFF : w_sum[31:0];
            end
            CMD_UP_RD:   addr = w_par[AW-1:0];
            CMD_UP_CMP: begin
                we = (rk < r_cur); addr = r_par; wdata = r_cur;
            end
            CMD_UP_WR: begin
                we = 1'b1; addr = r_pos; wdata = r_bestk;
            end
            CMD_DN_START: addr = w_first[AW-1:0];
            CMD_DN_SCAN:  addr = AW'(r_child + 1'b1);
            CMD_DN_SWAP: begin
                we = 1'b1; addr = r_pos; wdata = r_bestk;
            end
            CMD_DN_WR: begin
                we = 1'b1; addr = r_best; wdata = r_cur;
            end
            default: ;
        endcase
    end

    dhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == CMD_INS_WR) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.op == CMD_EXT_RD0) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_func <= i_func; r_key <= i_key; r_index <= i_index;
                r_amount <= i_amount; r_res <= '0;
                if (i_func == FUNC_INSERT && r_count >= CW'(CAPACITY)) r_st <= ST_FULL;
                else if (i_func == FUNC_EXTRACT && r_count == '0) r_st <= ST_EMPTY;
                else if (i_func == FUNC_INCREASE && {1'b0, i_index} >= r_count)
                    r_st <= ST_BADIDX;
                else r_st <= ST_OK;
            end
            CMD_INS_WR: begin
                r_pos <= r_count[AW-1:0]; r_cur <= r_key;
            end
            CMD_EXT_RDL: r_res <= rk;
            CMD_EXT_WR0: begin
                r_cur <= rk; r_pos <= '0;
            end
            CMD_INC_RD: r_pos <= r_index[AW-1:0];
            CMD_INC_WR: begin
                r_cur <= (w_sum > 33'sh7FFFFFFF) ? 32'sh7FFFFFFF : w_sum[31:0];
            end
            CMD_UP_RD: r_par <= w_par[AW-1:0];
            CMD_UP_CMP: r_bestk <= rk;
            CMD_UP_WR: r_pos <= r_par;
            CMD_DN_START: begin
                r_child <= w_first[AW-1:0];
                r_best <= w_first[AW-1:0];
                r_left <= w_d - 1'b1;
                r_bestk <= 32'sh80000000;
            end
            CMD_DN_SCAN: begin
                if (r_child == r_best || rk > r_bestk) begin
                    r_bestk <= rk; r_best <= r_child;
                end
                r_child <= AW'(r_child + 1'b1);
                r_left <= r_left - 1'b1;
            end
            CMD_DN_WR: r_pos <= r_best;
            default: ;
        endcase
        if (i_finish) begin
            o_max_key <= r_res; o_status <= r_st; o_count <= r_count;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.func      = r_func;
        o_stat.empty     = (r_st == ST_EMPTY);
        o_stat.full      = (r_st == ST_FULL);
        o_stat.bad_idx   = (r_st == ST_BADIDX);
        o_stat.at_root   = (r_pos == '0);
        o_stat.up_move   = (rk < r_cur);
        o_stat.dn_leaf   = (w_first >= {{(DW+1){1'b0}}, r_count});
        o_stat.scan_last = (r_left == '0) || (CW'(r_child) + 1'b1 >= r_count);
        o_stat.dn_move   = (r_cur < r_bestk);
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_count_cap, 1'b1, r_count <= CW'(CAPACITY))
    `ASSERT_NEXT(a_ins_grow, i_cmd.op == CMD_INS_WR, r_count == $past(r_count) + 1'b1)
    `ASSERT_IMPL(a_first_ok, i_cmd.op == CMD_DN_SCAN, {1'b0, r_child} < r_count)
endmodule
`default_nettype wire

// ----- hdl/dhpq_ctrl.sv -----
// Controller: sequences each operation over the datapath
`default_nettype none
module dhpq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    output dhpq_pkg::t_cmd      o_cmd,
    input  wire dhpq_pkg::t_stat i_stat,
    output logic                o_finish
);
    import dhpq_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_EXT1 = 4'd2,
        S_EXT3 = 4'd4, S_INC1 = 4'd5, S_INC2 = 4'd6, S_UPRD = 4'd7, S_UPCMP = 4'd8,
        S_UPWR = 4'd9, S_DNST = 4'd10, S_DNSC = 4'd12,
        S_DNDEC = 4'd13, S_DNWR = 4'd14, S_DONE = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       take;

    assign take = i_valid && !o_stall;
    // Busy while an item runs or a finished result cannot leave
    assign o_stall = (r_state != S_IDLE) || (r_valid && i_stall);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd.op = CMD_NONE;
        o_finish = 1'b0;
        n_valid = r_valid && i_stall;
        case (r_state)
            S_IDLE: if (take) begin
                o_cmd.op = CMD_LOAD; n_state = S_DISP;
            end
            S_DISP: begin
                if (i_stat.empty || i_stat.full || i_stat.bad_idx) n_state = S_DONE;
                else if (i_stat.func == FUNC_INSERT) begin
                    o_cmd.op = CMD_INS_WR; n_state = S_UPRD;
                end else if (i_stat.func == FUNC_EXTRACT) begin
                    o_cmd.op = CMD_EXT_RD0; n_state = S_EXT1;
                end else if (i_stat.func == FUNC_INCREASE) begin
                    o_cmd.op = CMD_INC_RD; n_state = S_INC1;
                end else n_state = S_DONE;
            end
            S_EXT1: begin o_cmd.op = CMD_EXT_RDL; n_state = S_EXT3; end
            S_EXT3: begin o_cmd.op = CMD_EXT_WR0; n_state = S_DNST; end
            S_INC1: n_state = S_INC2;
            S_INC2: begin o_cmd.op = CMD_INC_WR; n_state = S_UPRD; end
            S_UPRD: begin
                if (i_stat.at_root) n_state = S_DONE;
                else begin o_cmd.op = CMD_UP_RD; n_state = S_UPCMP; end
            end
            S_UPCMP: begin
                o_cmd.op = CMD_UP_CMP;
                n_state = i_stat.up_move ? S_UPWR : S_DONE;
            end
            S_UPWR: begin o_cmd.op = CMD_UP_WR; n_state = S_UPRD; end
            S_DNST: begin
                if (i_stat.dn_leaf) n_state = S_DONE;
                else begin o_cmd.op = CMD_DN_START; n_state = S_DNSC; end
            end
            S_DNSC: begin
                o_cmd.op = CMD_DN_SCAN;
                n_state = i_stat.scan_last ? S_DNDEC : S_DNSC;
            end
            S_DNDEC: begin
                if (i_stat.dn_move) begin o_cmd.op = CMD_DN_SWAP; n_state = S_DNWR; end
                else n_state = S_DONE;
            end
            S_DNWR: begin o_cmd.op = CMD_DN_WR; n_state = S_DNST; end
            S_DONE: if (!(r_valid && i_stall)) begin
                o_finish = 1'b1; n_valid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_take_busy, r_state != S_IDLE, !take)
    `ASSERT_NEXT(a_finish_valid, o_finish, r_valid)
endmodule
`default_nettype wire

// ----- verif/tb_dary_max_heap_priority_queue_unit.sv -----
// Testbench for the d-ary max-heap priority queue: predicts every transfer and checks results
`default_nettype none
module tb_dary_max_heap_priority_queue_unit;
    import dhpq_pkg::*;

    // Operation code with no effect
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Expected result of one operation
    typedef struct {
        logic signed [31:0] max_key;
        logic [1:0]         status;
        logic [CW-1:0]      count;
    } t_heap_result;

    // Scoreboard: own copy of the heap, queue of pending results
    class heap_scoreboard;
        logic signed [31:0] keys [CAPACITY];
        int unsigned        fill;
        logic [DW-1:0]      degree_reg;
        t_heap_result       pending [$];
        int                 mismatches;

        function new();
            fill = 0;
            degree_reg = 4'd2;
            mismatches = 0;
        endfunction

        function int unsigned span();
            if (degree_reg < 2) return 2;
            if (degree_reg > MAX_DEGREE) return MAX_DEGREE;
            return degree_reg;
        endfunction

        function void swap_keys(int unsigned a, int unsigned b);
            logic signed [31:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void rise(int unsigned pos);
            int unsigned par;
            while (pos > 0) begin
                par = (pos - 1) / span();
                if (keys[pos] <= keys[par]) break;
                swap_keys(pos, par);
                pos = par;
            end
        endfunction

        function void sink(int unsigned pos);
            int unsigned first, last, best;
            while (pos < fill) begin
                first = pos * span() + 1;
                if (first >= fill) break;
                last = first + span() - 1;
                if (last >= fill) last = fill - 1;
                best = first;
                for (int unsigned c = first + 1; c <= last; c++)
                    if (keys[c] > keys[best]) best = c;
                if (keys[pos] >= keys[best]) break;
                swap_keys(pos, best);
                pos = best;
            end
        endfunction

        // Note an accepted input transfer
        function void note_item(logic [1:0] func, logic signed [31:0] key,
                                logic [7:0] index, logic [30:0] amount);
            t_heap_result r;
            longint sum;
            r.max_key = 0;
            r.status = ST_OK;
            if (func == FUNC_INSERT) begin
                if (fill >= CAPACITY) r.status = ST_FULL;
                else begin
                    keys[fill] = key;
                    fill++;
                    rise(fill - 1);
                end
            end else if (func == FUNC_EXTRACT) begin
                if (fill == 0) r.status = ST_EMPTY;
                else begin
                    r.max_key = keys[0];
                    fill--;
                    keys[0] = keys[fill];
                    sink(0);
                end
            end else if (func == FUNC_INCREASE) begin
                if (index >= fill) r.status = ST_BADIDX;
                else begin
                    sum = longint'(keys[index]) + longint'(amount);
                    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                    keys[index] = sum[31:0];
                    rise(index);
                end
            end
            r.count = fill[CW-1:0];
            pending = {pending, r};
        endfunction

        // Check one result transfer against the oldest expectation
        function void check_result(logic signed [31:0] max_key, logic [1:0] status,
                                   logic [CW-1:0] count);
            t_heap_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: key %0d status %0d count %0d",
                                               max_key, status, count);
                return;
            end
            e = pending.pop_front();
            if (max_key !== e.max_key || status !== e.status || count !== e.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp key %0d st %0d cnt %0d, got key %0d st %0d cnt %0d",
                             e.max_key, e.status, e.count, max_key, status, count);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic signed [31:0] i_key;
    logic [7:0]         i_index;
    logic [30:0]        i_amount;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_max_key;
    logic [1:0]         o_status;
    logic [CW-1:0]      o_count;
    logic               i_degree_we;
    logic [DW-1:0]      i_degree;

    heap_scoreboard sb;
    bit             calm;       // no idling in the final stretch
    int             idle_cycles;

    dary_max_heap_priority_queue_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_key(i_key), .i_index(i_index), .i_amount(i_amount),
        .o_valid(o_valid), .i_stall(i_stall), .o_max_key(o_max_key),
        .o_status(o_status), .o_count(o_count), .i_degree_we(i_degree_we),
        .i_degree(i_degree)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, result checking
    initial begin
        int burst;
        i_stall = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result(o_max_key, o_status, o_count);
            if (burst > 0) burst--;
            else if (!calm && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 12);
            i_stall <= (burst > 0);
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Send one item and wait for its transfer; valid stays up for a following item
    task automatic send_item(logic [1:0] func, logic signed [31:0] key,
                             logic [7:0] index, logic [30:0] amount);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= func;
        i_key    <= key;
        i_index  <= index;
        i_amount <= amount;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(func, key, index, amount);
    endtask

    // Wait until every pending result has arrived, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_degree(logic [DW-1:0] d);
        i_degree_we <= 1'b1;
        i_degree    <= d;
        @(posedge i_clk);
        i_degree_we <= 1'b0;
        sb.degree_reg = d;
    endtask

    // Random operation, mostly well-formed against the predicted fill level
    task automatic random_item(int ins_bias);
        int pick;
        logic [31:0] k;
        pick = $urandom_range(0, 99);
        k = $urandom();
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 40) - 20;
        if (pick < ins_bias)
            send_item(FUNC_INSERT, k, 8'($urandom()), 31'($urandom()));
        else if (pick < 80)
            send_item(FUNC_EXTRACT, $urandom(), 8'($urandom()), 31'($urandom()));
        else if (pick < 97)
            send_item(FUNC_INCREASE, $urandom(),
                      (sb.fill > 0 && $urandom_range(0, 5) != 0) ?
                          8'($urandom_range(0, sb.fill - 1)) : 8'($urandom()),
                      ($urandom_range(0, 3) == 0) ? 31'($urandom()) :
                          31'($urandom_range(0, 1000)));
        else
            send_item(FUNC_SPARE, $urandom(), 8'($urandom()), 31'($urandom()));
    endtask

    initial begin
        logic [DW-1:0] degs [6] = '{4'd2, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5};
        sb = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = '0;
        i_key = '0;
        i_index = '0;
        i_amount = '0;
        i_degree_we = 1'b0;
        i_degree = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-heap errors, extremes, ties, saturation, unused code
        send_item(FUNC_EXTRACT, 32'sd0, 8'd0, 31'd0);
        send_item(FUNC_INCREASE, 32'sd0, 8'd0, 31'd5);
        send_item(FUNC_INCREASE, 32'sd0, 8'hFF, 31'h7FFFFFFF);
        send_item(FUNC_INSERT, 32'sh80000000, 8'd0, 31'd0);
        send_item(FUNC_INSERT, 32'sh7FFFFFFF, 8'd0, 31'd0);
        send_item(FUNC_INSERT, 32'sd7, 8'd0, 31'd0);
        send_item(FUNC_INSERT, 32'sd7, 8'd0, 31'd0);
        send_item(FUNC_INSERT, -32'sd1, 8'd0, 31'd0);
        send_item(FUNC_INCREASE, 32'sd0, 8'd1, 31'h7FFFFFFF);
        send_item(FUNC_INCREASE, 32'sd0, 8'd4, 31'd8);
        send_item(FUNC_INCREASE, 32'sd0, 8'd5, 31'd1);
        send_item(FUNC_SPARE, 32'shFFFFFFFF, 8'hFF, 31'h7FFFFFFF);
        repeat (6) send_item(FUNC_EXTRACT, 32'sd0, 8'd0, 31'd0);
        drain();

        // Fill to capacity, hit full, then empty again
        set_degree(4'd8);
        repeat (CAPACITY) send_item(FUNC_INSERT, $urandom(), 8'd0, 31'd0);
        send_item(FUNC_INSERT, 32'sd1, 8'd0, 31'd0);
        send_item(FUNC_INCREASE, 32'sd0, 8'hFF, 31'd3);
        repeat (CAPACITY + 1) send_item(FUNC_EXTRACT, 32'sd0, 8'd0, 31'd0);
        drain();

        // Random phases over several degree settings
        foreach (degs[p]) begin
            set_degree(degs[p]);
            for (int i = 0; i < 30; i++) begin
                if (p == 5 && i == 15) calm = 1'b1;
                random_item((i < 15) ? 55 : 35);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
